// File: rtl/pipeline_scoreboard_assert.svh
// Assertion macros shared by the scoreboard checker.
// Depends on signals named clk and rst_n in the including scope.
`ifndef PIPELINE_SCOREBOARD_ASSERT_SVH
`define PIPELINE_SCOREBOARD_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scoreboard check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scoreboard check failed");

// Next-cycle implication that also holds across reset.
`define PSB_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scoreboard reset check failed");

`endif

// File: rtl/psb_pkg.sv
// Types and constants of the pipeline hazard scoreboard.
// Used by every module of the block; depends on nothing.
package psb_pkg;

  localparam int unsigned NREGS     = 8;
  localparam int unsigned REG_W     = 3;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned MASK_W    = 6;
  localparam int unsigned OFF_W     = 6;

  localparam logic [CNT_W-1:0]  COUNT_MAX = 4'd15;
  localparam logic [ADDR_W-1:0] KEY_MASK  = 16'hFFFE;

  // Bit positions within the dependency mask.
  localparam int unsigned DEP_SRC1   = 0;
  localparam int unsigned DEP_SRC2   = 1;
  localparam int unsigned DEP_RDMEM  = 2;
  localparam int unsigned DEP_WRDEST = 3;
  localparam int unsigned DEP_WRMEM  = 4;
  localparam int unsigned DEP_WRPC   = 5;

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_ISSUE  = 2'd1,
    OP_RETIRE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_FULL      = 2'd1,
    ERR_NOT_FOUND = 2'd2,
    ERR_UNDERFLOW = 2'd3
  } err_t;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [MASK_W-1:0]      dep_flags;
    logic [REG_W-1:0]       src1;
    logic [REG_W-1:0]       src2;
    logic [REG_W-1:0]       dest;
    logic                   addr_known;
    logic [ADDR_W-1:0]      mem_addr;
    logic [ADDR_W-1:0]      base_value;
    logic signed [OFF_W-1:0] offset;
    logic                   word_load;
  } item_t;

  typedef struct packed {
    logic              stall_res;
    logic              addr_valid;
    logic [ADDR_W-1:0] addr_out;
    logic              branch_pending;
    err_t              error;
  } result_t;

endpackage

// File: rtl/psb_addr.sv
// Effective address former: base plus sign-extended offset, doubled for words.
// Depends on psb_pkg.
module psb_addr
  import psb_pkg::*;
(
  input  logic [ADDR_W-1:0]        base_value,
  input  logic signed [OFF_W-1:0]  offset,
  input  logic                     word_load,
  output logic [ADDR_W-1:0]        addr
);

  logic [OFF_W:0] off_scaled;

  always_comb begin
    if (word_load) begin
      off_scaled = {offset, 1'b0};
    end else begin
      off_scaled = {offset[OFF_W-1], offset};
    end
  end

  // The sum wraps at the address width.
  assign addr = base_value + {{(ADDR_W-OFF_W-1){off_scaled[OFF_W]}}, off_scaled};

endmodule

// File: rtl/psb_core.sv
// Scoreboard state (pending counts, store table, branch flag) and hazard logic.
// Depends on psb_pkg and psb_addr.
module psb_core
  import psb_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 8
)
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output result_t result
);

  logic [CNT_W-1:0]  reg_pending_r [NREGS];
  logic [ADDR_W-1:0] store_table_r [TABLE_SLOTS];
  logic              branch_r;
  logic              branch_nxt;

  logic [ADDR_W-1:0]      calc_addr;
  logic [ADDR_W-1:0]      eff;
  logic [ADDR_W-1:0]      key;
  logic                   key_nz;
  logic [TABLE_SLOTS-1:0] hit;
  logic [TABLE_SLOTS-1:0] free;
  logic [TABLE_SLOTS-1:0] hit_lo;
  logic [TABLE_SLOTS-1:0] free_lo;
  logic [TABLE_SLOTS-1:0] slot_we;
  logic [ADDR_W-1:0]      slot_wdata;
  logic                   cnt_we;
  logic [CNT_W-1:0]       cnt_wdata;
  logic [CNT_W-1:0]       cnt_s1;
  logic [CNT_W-1:0]       cnt_s2;
  logic [CNT_W-1:0]       cnt_d;

  psb_addr u_addr (
    .base_value (item.base_value),
    .offset     (item.offset),
    .word_load  (item.word_load),
    .addr       (calc_addr)
  );

  assign eff    = item.addr_known ? item.mem_addr : calc_addr;
  assign key    = eff & KEY_MASK;
  assign key_nz = |key;
  assign cnt_s1 = reg_pending_r[item.src1];
  assign cnt_s2 = reg_pending_r[item.src2];
  assign cnt_d  = reg_pending_r[item.dest];

  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      hit[i]  = (store_table_r[i] == key);
      free[i] = (store_table_r[i] == '0);
    end
  end

  // Isolate the lowest set bit so duplicates resolve to the lowest slot.
  assign hit_lo  = hit & (~hit + 1'b1);
  assign free_lo = free & (~free + 1'b1);

  always_comb begin
    result            = '0;
    result.error      = ERR_NONE;
    branch_nxt        = branch_r;
    slot_we           = '0;
    slot_wdata        = '0;
    cnt_we            = 1'b0;
    cnt_wdata         = cnt_d;
    case (item.opcode)
      OP_CHECK: begin
        if (item.dep_flags[DEP_SRC1] && (cnt_s1 != '0)) begin
          result.stall_res = 1'b1;
        end else if (item.dep_flags[DEP_SRC2] && (cnt_s2 != '0)) begin
          result.stall_res = 1'b1;
        end else if (item.dep_flags[DEP_RDMEM]) begin
          // An unknown address cannot be formed while its base is in flight.
          if (!item.addr_known && (cnt_s1 != '0)) begin
            result.stall_res = 1'b1;
          end else begin
            if (!item.addr_known) begin
              result.addr_valid = 1'b1;
              result.addr_out   = eff;
            end
            if (key_nz && (|hit)) begin
              result.stall_res = 1'b1;
            end
          end
        end
      end
      OP_ISSUE: begin
        if (item.dep_flags[DEP_WRPC]) begin
          branch_nxt = 1'b1;
        end
        if (item.dep_flags[DEP_WRDEST] && (cnt_d != COUNT_MAX)) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_d + 1'b1;
        end
        if (item.dep_flags[DEP_WRMEM] && key_nz) begin
          if (|free) begin
            slot_we    = free_lo;
            slot_wdata = key;
          end else begin
            result.error = ERR_FULL;
          end
        end
      end
      OP_RETIRE: begin
        if (item.dep_flags[DEP_WRPC]) begin
          branch_nxt = 1'b0;
        end
        if (item.dep_flags[DEP_WRMEM] && key_nz) begin
          if (|hit) begin
            slot_we = hit_lo;
          end else begin
            result.error = ERR_NOT_FOUND;
          end
        end
        if (item.dep_flags[DEP_WRDEST]) begin
          if (cnt_d != '0) begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_d - 1'b1;
          end else if (result.error == ERR_NONE) begin
            result.error = ERR_UNDERFLOW;
          end
        end
      end
      default: begin
      end
    endcase
    result.branch_pending = branch_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      branch_r <= 1'b0;
      for (int i = 0; i < NREGS; i++) begin
        reg_pending_r[i] <= '0;
      end
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        store_table_r[i] <= '0;
      end
    end else if (step) begin
      branch_r <= branch_nxt;
      if (cnt_we) begin
        reg_pending_r[item.dest] <= cnt_wdata;
      end
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (slot_we[i]) begin
          store_table_r[i] <= slot_wdata;
        end
      end
    end
  end

endmodule

// File: rtl/pipeline_scoreboard.sv
// Pipeline hazard scoreboard: input register, hazard core, output register.
// Depends on psb_pkg and psb_core.
//
// Usage: each input word carries one scoreboard operation (check, issue or
// retire) with its dependency mask, register numbers and address fields.
// Every accepted word produces exactly one result word: the stall verdict,
// a computed address for memory reads, the branch flag after the step and
// an error code for issue and retire.
// Both channels use valid/ready. A word is registered on acceptance and is
// evaluated against the scoreboard once the output register is free or
// being read; its result is registered then and out_valid rises. One word
// per cycle is sustained while out_ready stays high; the rate is set by
// the single read-modify-write of the scoreboard state per cycle.
// When the receiver holds out_ready low, the result stays put, the word in
// the input register waits, and in_ready drops once both are occupied.
// Reset (synchronous, active low) clears all pending counts, frees every
// store-table slot, clears the branch flag and empties both registers.
module pipeline_scoreboard
  import psb_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 8
)
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_opcode,
  input  logic [MASK_W-1:0]       in_dep_flags,
  input  logic [REG_W-1:0]        in_src1,
  input  logic [REG_W-1:0]        in_src2,
  input  logic [REG_W-1:0]        in_dest,
  input  logic                    in_addr_known,
  input  logic [ADDR_W-1:0]       in_mem_addr,
  input  logic [ADDR_W-1:0]       in_base_value,
  input  logic signed [OFF_W-1:0] in_offset,
  input  logic                    in_word_load,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_stall_res,
  output logic                    out_addr_valid,
  output logic [ADDR_W-1:0]       out_addr_out,
  output logic                    out_branch_pending,
  output logic [1:0]              out_error
);

  item_t   item_r;
  logic    item_valid_r;
  result_t res_r;
  logic    out_valid_r;
  result_t res_nxt;
  logic    advance;

  assign advance  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  psb_core #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item_r),
    .result (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.opcode     <= in_opcode;
      item_r.dep_flags  <= in_dep_flags;
      item_r.src1       <= in_src1;
      item_r.src2       <= in_src2;
      item_r.dest       <= in_dest;
      item_r.addr_known <= in_addr_known;
      item_r.mem_addr   <= in_mem_addr;
      item_r.base_value <= in_base_value;
      item_r.offset     <= in_offset;
      item_r.word_load  <= in_word_load;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_stall_res      = res_r.stall_res;
  assign out_addr_valid     = res_r.addr_valid;
  assign out_addr_out       = res_r.addr_out;
  assign out_branch_pending = res_r.branch_pending;
  assign out_error          = res_r.error;

endmodule

// File: rtl/psb_checker.sv
// Port-level checker for the pipeline scoreboard, bound to the top level.
// Depends on psb_pkg and pipeline_scoreboard_assert.svh.
`include "pipeline_scoreboard_assert.svh"

module psb_checker
  import psb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_stall_res,
  input  logic              out_addr_valid,
  input  logic [ADDR_W-1:0] out_addr_out,
  input  logic              out_branch_pending,
  input  logic [1:0]        out_error
);

  // A result word that is not taken stays on the port, with its address, error and branch fields unchanged.
  `PSB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_addr_out) && $stable(out_error) && $stable(out_branch_pending))

  // Stalls and computed addresses only come from checks, which never report errors.
  `PSB_ASSERT_IMP(a_check_no_error, out_valid && (out_stall_res || out_addr_valid), out_error == ERR_NONE)

  // Without a computed address the address field reads zero.
  `PSB_ASSERT_IMP(a_addr_zero, out_valid && !out_addr_valid, out_addr_out == '0)

  // Reset empties the result register.
  `PSB_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind pipeline_scoreboard psb_checker u_psb_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_stall_res      (out_stall_res),
  .out_addr_valid     (out_addr_valid),
  .out_addr_out       (out_addr_out),
  .out_branch_pending (out_branch_pending),
  .out_error          (out_error)
);

// File: verif/tb_pipeline_scoreboard.sv
// Self-checking testbench for the pipeline hazard scoreboard (pipeline_scoreboard).
// Depends on psb_pkg and the RTL of the block. It drives directed and random words,
// and compares every result with a table entry or with its own model of the scoreboard state.
`timescale 1ns / 100ps

module tb_pipeline_scoreboard;
  import psb_pkg::*;

  localparam int unsigned TABLE_SLOTS = 8;
  localparam int          IDLE_PCT    = 35;
  localparam int          HOLD_CYCLES = 80;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DIR_ROWS    = 21;
  localparam int          POOL_N      = 10;
  localparam int          POOL_IW     = $clog2(POOL_N);
  localparam int          PRINT_MAX   = 50;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  localparam logic [MASK_W-1:0] M_SRC1   = 6'(1 << DEP_SRC1);
  localparam logic [MASK_W-1:0] M_SRC2   = 6'(1 << DEP_SRC2);
  localparam logic [MASK_W-1:0] M_RDMEM  = 6'(1 << DEP_RDMEM);
  localparam logic [MASK_W-1:0] M_WRDEST = 6'(1 << DEP_WRDEST);
  localparam logic [MASK_W-1:0] M_WRMEM  = 6'(1 << DEP_WRMEM);
  localparam logic [MASK_W-1:0] M_WRPC   = 6'(1 << DEP_WRPC);
  localparam logic [MASK_W-1:0] M_ALL    = 6'h3F;

  localparam result_t NO_RESULT = '0;

  // Addresses that collide often, including the ones whose key is zero.
  localparam logic [ADDR_W-1:0] ADDR_POOL [POOL_N] = '{
    16'h0000, 16'h0001, 16'h8000, 16'h8001, 16'hFFFE,
    16'hFFFF, 16'h1234, 16'h1235, 16'h00F0, 16'h4002
  };

  typedef struct {
    item_t   it;
    int      reps;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_opcode;
  logic [MASK_W-1:0] in_dep_flags;
  logic [REG_W-1:0] in_src1;
  logic [REG_W-1:0] in_src2;
  logic [REG_W-1:0] in_dest;
  logic in_addr_known;
  logic [ADDR_W-1:0] in_mem_addr;
  logic [ADDR_W-1:0] in_base_value;
  logic signed [OFF_W-1:0] in_offset;
  logic in_word_load;
  logic out_valid;
  logic out_ready;
  logic out_stall_res;
  logic out_addr_valid;
  logic [ADDR_W-1:0] out_addr_out;
  logic out_branch_pending;
  logic [1:0] out_error;

  // Shadow of the scoreboard state.
  logic [CNT_W-1:0]  writer_cnt [NREGS];
  logic [ADDR_W-1:0] store_keys [TABLE_SLOTS];
  logic              branch_flag_q;

  result_t   responses_due [$];
  stim_row_t dir_rows [DIR_ROWS];
  int        mismatch_cnt;
  int        rx_count;
  int        cycle_cnt;
  bit        tx_calm;
  bit        rx_calm;
  bit        hold_req;

  pipeline_scoreboard #(.TABLE_SLOTS(TABLE_SLOTS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_dep_flags(in_dep_flags),
    .in_src1(in_src1), .in_src2(in_src2), .in_dest(in_dest),
    .in_addr_known(in_addr_known), .in_mem_addr(in_mem_addr),
    .in_base_value(in_base_value), .in_offset(in_offset),
    .in_word_load(in_word_load),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_stall_res(out_stall_res), .out_addr_valid(out_addr_valid),
    .out_addr_out(out_addr_out), .out_branch_pending(out_branch_pending),
    .out_error(out_error)
  );

  always #5 clk = ~clk;

  function automatic item_t mk_item(input logic [1:0] op, input logic [MASK_W-1:0] mask,
                                    input int s1, input int s2, input int d,
                                    input bit known, input logic [ADDR_W-1:0] addr,
                                    input logic [ADDR_W-1:0] base, input int off,
                                    input bit word);
    item_t it;
    it.opcode     = op;
    it.dep_flags  = mask;
    it.src1       = REG_W'(s1);
    it.src2       = REG_W'(s2);
    it.dest       = REG_W'(d);
    it.addr_known = known;
    it.mem_addr   = addr;
    it.base_value = base;
    it.offset     = OFF_W'(off);
    it.word_load  = word;
    return it;
  endfunction

  function automatic result_t mk_res(input bit stall, input bit av,
                                     input logic [ADDR_W-1:0] aout, input bit br,
                                     input err_t e);
    result_t r;
    r.stall_res      = stall;
    r.addr_valid     = av;
    r.addr_out       = aout;
    r.branch_pending = br;
    r.error          = e;
    return r;
  endfunction

  // Applies one word to the shadow state and returns the response it causes.
  function automatic result_t hazard_response(input item_t it);
    result_t           r;
    logic [ADDR_W-1:0] off_ext;
    logic [ADDR_W-1:0] eff;
    logic [ADDR_W-1:0] key;
    int                hit;
    int                free_slot;
    r = NO_RESULT;
    off_ext = {{(ADDR_W-OFF_W){it.offset[OFF_W-1]}}, it.offset};
    if (it.word_load) off_ext = off_ext << 1;
    eff = it.addr_known ? it.mem_addr : it.base_value + off_ext;
    key = eff & KEY_MASK;
    hit = -1;
    free_slot = -1;
    // Walk downward so that the lowest matching and lowest free slots win.
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (store_keys[i] == key) hit = i;
      if (store_keys[i] == '0) free_slot = i;
    end
    case (it.opcode)
      OP_CHECK: begin
        if (it.dep_flags[DEP_SRC1] && writer_cnt[it.src1] != '0) begin
          r.stall_res = 1'b1;
        end else if (it.dep_flags[DEP_SRC2] && writer_cnt[it.src2] != '0) begin
          r.stall_res = 1'b1;
        end else if (it.dep_flags[DEP_RDMEM]) begin
          if (!it.addr_known && writer_cnt[it.src1] != '0) begin
            r.stall_res = 1'b1;
          end else begin
            if (!it.addr_known) begin
              r.addr_valid = 1'b1;
              r.addr_out   = eff;
            end
            if (key != '0 && hit >= 0) r.stall_res = 1'b1;
          end
        end
      end
      OP_ISSUE: begin
        if (it.dep_flags[DEP_WRPC]) branch_flag_q = 1'b1;
        if (it.dep_flags[DEP_WRDEST] && writer_cnt[it.dest] != COUNT_MAX)
          writer_cnt[it.dest] = writer_cnt[it.dest] + 1'b1;
        if (it.dep_flags[DEP_WRMEM] && key != '0) begin
          if (free_slot >= 0) store_keys[free_slot] = key;
          else r.error = ERR_FULL;
        end
      end
      OP_RETIRE: begin
        if (it.dep_flags[DEP_WRPC]) branch_flag_q = 1'b0;
        if (it.dep_flags[DEP_WRMEM] && key != '0) begin
          if (hit >= 0) store_keys[hit] = '0;
          else r.error = ERR_NOT_FOUND;
        end
        // A missing store address outranks an underflowing count.
        if (it.dep_flags[DEP_WRDEST]) begin
          if (writer_cnt[it.dest] != '0) writer_cnt[it.dest] = writer_cnt[it.dest] - 1'b1;
          else if (r.error == ERR_NONE) r.error = ERR_UNDERFLOW;
        end
      end
      default: ;
    endcase
    r.branch_pending = branch_flag_q;
    return r;
  endfunction

  function automatic item_t random_word();
    item_t it;
    int    r;
    r = $urandom_range(99);
    if (r < 2)       it.opcode = OP_UNUSED;
    else if (r < 47) it.opcode = OP_CHECK;
    else if (r < 75) it.opcode = OP_ISSUE;
    else             it.opcode = OP_RETIRE;
    it.dep_flags  = MASK_W'($urandom);
    it.src1       = REG_W'($urandom_range(NREGS - 1));
    it.src2       = REG_W'($urandom_range(NREGS - 1));
    it.dest       = REG_W'($urandom_range(NREGS - 1));
    it.addr_known = 1'($urandom_range(1));
    it.mem_addr   = ($urandom_range(99) < 75) ?
                    ADDR_POOL[POOL_IW'($urandom_range(POOL_N - 1))] : ADDR_W'($urandom);
    it.base_value = ($urandom_range(1) == 0) ?
                    ADDR_POOL[POOL_IW'($urandom_range(POOL_N - 1))] : ADDR_W'($urandom);
    it.offset     = OFF_W'($urandom);
    it.word_load  = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] got_v,
                                 input logic [ADDR_W-1:0] want_v);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_MAX)
      $display("result %0d: %s is %0h, expected %0h", rx_count, field, got_v, want_v);
  endtask

  // Offers one word and records its response once the block takes it.
  task automatic send_word(input item_t it, input result_t want, input bit typed);
    result_t pred;
    while (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= it.opcode;
    in_dep_flags  <= it.dep_flags;
    in_src1       <= it.src1;
    in_src2       <= it.src2;
    in_dest       <= it.dest;
    in_addr_known <= it.addr_known;
    in_mem_addr   <= it.mem_addr;
    in_base_value <= it.base_value;
    in_offset     <= it.offset;
    in_word_load  <= it.word_load;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = hazard_response(it);
    responses_due.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (responses_due.size() != 0) @(posedge clk);
  endtask

  // Mostly random words, with occasional runs of issues to one register and
  // one store address followed by the matching retires, which can saturate the
  // counts and fill the store table.
  task automatic run_random(input int n_words);
    item_t             it;
    int                left;
    int                k;
    int                d;
    logic [ADDR_W-1:0] a;
    left = n_words;
    while (left > 0) begin
      if ($urandom_range(99) < 1) begin
        k = $urandom_range(10, 18);
        d = $urandom_range(NREGS - 1);
        a = ADDR_POOL[POOL_IW'($urandom_range(POOL_N - 1))];
        for (int i = 0; i < 2 * k; i++) begin
          it = random_word();
          it.opcode = (i < k) ? OP_ISSUE : OP_RETIRE;
          it.dep_flags[DEP_WRDEST] = 1'b1;
          it.dep_flags[DEP_WRMEM]  = 1'b1;
          it.dest       = REG_W'(d);
          it.addr_known = 1'b1;
          it.mem_addr   = a;
          send_word(it, NO_RESULT, 1'b0);
        end
        left -= 2 * k;
      end else begin
        send_word(random_word(), NO_RESULT, 1'b0);
        left--;
      end
    end
  endtask

  initial begin
    dir_rows[0]  = '{mk_item(OP_CHECK, M_SRC1 | M_SRC2 | M_RDMEM, 0, 1, 0, 1, 16'h1234,
                             16'h0000, 0, 0), 1, 1, mk_res(0, 0, 16'h0000, 0, ERR_NONE)};
    dir_rows[1]  = '{mk_item(OP_CHECK, M_RDMEM, 0, 0, 0, 0, 16'h0000, 16'hFFFF, 31, 1),
                     1, 1, mk_res(0, 1, 16'h003D, 0, ERR_NONE)};
    dir_rows[2]  = '{mk_item(OP_CHECK, M_RDMEM, 0, 0, 0, 0, 16'h0000, 16'h0000, -32, 0),
                     1, 1, mk_res(0, 1, 16'hFFE0, 0, ERR_NONE)};
    dir_rows[3]  = '{mk_item(OP_RETIRE, M_WRDEST, 0, 0, 7, 1, 16'h0000, 16'h0000, 0, 0),
                     1, 1, mk_res(0, 0, 16'h0000, 0, ERR_UNDERFLOW)};
    dir_rows[4]  = '{mk_item(OP_RETIRE, M_WRMEM, 0, 0, 0, 1, 16'h5001, 16'h0000, 0, 0),
                     1, 1, mk_res(0, 0, 16'h0000, 0, ERR_NOT_FOUND)};
    dir_rows[5]  = '{mk_item(OP_RETIRE, M_WRMEM | M_WRDEST, 0, 0, 2, 1, 16'hABCD, 16'h0000,
                             0, 0), 1, 1, mk_res(0, 0, 16'h0000, 0, ERR_NOT_FOUND)};
    // A store to address one has a zero key, so it is never recorded.
    dir_rows[6]  = '{mk_item(OP_ISSUE, M_WRPC | M_WRMEM | M_WRDEST, 0, 0, 3, 1, 16'h0001,
                             16'h0000, 0, 0), 1, 1, mk_res(0, 0, 16'h0000, 1, ERR_NONE)};
    dir_rows[7]  = '{mk_item(OP_CHECK, M_SRC1, 3, 0, 0, 1, 16'h0000, 16'h0000, 0, 0),
                     1, 0, NO_RESULT};
    dir_rows[8]  = '{mk_item(OP_CHECK, M_SRC2, 0, 3, 0, 1, 16'h0000, 16'h0000, 0, 0),
                     1, 0, NO_RESULT};
    dir_rows[9]  = '{mk_item(OP_CHECK, M_RDMEM, 3, 0, 0, 0, 16'h0000, 16'h0100, 4, 0),
                     1, 0, NO_RESULT};
    dir_rows[10] = '{mk_item(OP_CHECK, M_RDMEM, 3, 0, 0, 1, 16'h0000, 16'h0000, 0, 0),
                     1, 0, NO_RESULT};
    dir_rows[11] = '{mk_item(OP_ISSUE, M_WRMEM, 0, 0, 0, 1, 16'h8001, 16'h0000, 0, 0),
                     1, 0, NO_RESULT};
    dir_rows[12] = '{mk_item(OP_CHECK, M_RDMEM, 0, 0, 0, 1, 16'h8000, 16'h0000, 0, 0),
                     1, 0, NO_RESULT};
    dir_rows[13] = '{mk_item(OP_CHECK, M_RDMEM, 0, 0, 0, 0, 16'h0000, 16'h7FFF, 1, 1),
                     1, 0, NO_RESULT};
    // Duplicates fill the rest of the table; the last one finds it full.
    dir_rows[14] = '{mk_item(OP_ISSUE, M_WRMEM, 0, 0, 0, 0, 16'h0000, 16'h8000, 0, 0),
                     TABLE_SLOTS, 0, NO_RESULT};
    dir_rows[15] = '{mk_item(OP_RETIRE, M_WRMEM, 0, 0, 0, 1, 16'h8001, 16'h0000, 0, 0),
                     1, 0, NO_RESULT};
    dir_rows[16] = '{mk_item(OP_ISSUE, M_WRMEM, 0, 0, 0, 1, 16'hFFFF, 16'h0000, 0, 0),
                     1, 0, NO_RESULT};
    dir_rows[17] = '{mk_item(OP_RETIRE, M_WRPC, 0, 0, 0, 1, 16'h0000, 16'h0000, 0, 0),
                     1, 0, NO_RESULT};
    dir_rows[18] = '{mk_item(OP_UNUSED, M_ALL, 7, 7, 7, 1, 16'hFFFF, 16'hFFFF, -1, 1),
                     1, 1, mk_res(0, 0, 16'h0000, 0, ERR_NONE)};
    dir_rows[19] = '{mk_item(OP_CHECK, M_ALL, 7, 7, 7, 0, 16'hFFFF, 16'hFFFF, -1, 1),
                     1, 0, NO_RESULT};
    dir_rows[20] = '{mk_item(OP_RETIRE, M_ALL, 0, 0, 3, 1, 16'hFFFF, 16'h0000, 0, 0),
                     1, 0, NO_RESULT};

    for (int i = 0; i < NREGS; i++) writer_cnt[i] = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) store_keys[i] = '0;
    branch_flag_q = 1'b0;
    mismatch_cnt  = 0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    hold_req      = 1'b0;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= OP_CHECK;
    in_dep_flags  <= '0;
    in_src1       <= '0;
    in_src2       <= '0;
    in_dest       <= '0;
    in_addr_known <= 1'b0;
    in_mem_addr   <= '0;
    in_base_value <= '0;
    in_offset     <= '0;
    in_word_load  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++)
      repeat (dir_rows[r].reps) send_word(dir_rows[r].it, dir_rows[r].want, dir_rows[r].typed);
    wait_drained();

    run_random(400);

    // The receiver holds off while words keep coming, so the block backs up.
    hold_req = 1'b1;
    tx_calm  = 1'b1;
    run_random(120);
    tx_calm  = 1'b0;
    wait_drained();

    tx_calm = 1'b1;
    rx_calm = 1'b1;
    run_random(200);
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    run_random(380);
    wait_drained();
    repeat (4) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("tb_pipeline_scoreboard: PASS");
    else
      $display("tb_pipeline_scoreboard: FAIL");
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.stall_res      = out_stall_res;
      got.addr_valid     = out_addr_valid;
      got.addr_out       = out_addr_out;
      got.branch_pending = out_branch_pending;
      got.error          = err_t'(out_error);
      if (responses_due.size() == 0) begin
        report_mismatch("unexpected word", ADDR_W'(got.addr_out), '0);
      end else begin
        want = responses_due.pop_front();
        if (got.stall_res !== want.stall_res)
          report_mismatch("stall_res", ADDR_W'(got.stall_res), ADDR_W'(want.stall_res));
        if (got.addr_valid !== want.addr_valid)
          report_mismatch("addr_valid", ADDR_W'(got.addr_valid), ADDR_W'(want.addr_valid));
        if (got.addr_out !== want.addr_out)
          report_mismatch("addr_out", got.addr_out, want.addr_out);
        if (got.branch_pending !== want.branch_pending)
          report_mismatch("branch_pending", ADDR_W'(got.branch_pending),
                          ADDR_W'(want.branch_pending));
        if (got.error !== want.error)
          report_mismatch("error", ADDR_W'(got.error), ADDR_W'(want.error));
      end
      rx_count++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_pipeline_scoreboard: FAIL");
      $finish;
    end
  end

  initial begin
    cycle_cnt = 0;
    rx_count  = 0;
  end

endmodule
